// ----- src/dual_psg_tone_noise_mixer_defines.svh -----
// Assertion macros used by the checker in dpsg_checker.sv.
`ifndef DUAL_PSG_TONE_NOISE_MIXER_DEFINES_SVH
`define DUAL_PSG_TONE_NOISE_MIXER_DEFINES_SVH

// Clocked assertion that is switched off while reset is high.
`define DPSG_ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define DPSG_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/dpsg_pkg.sv -----
`default_nettype none
package dpsg_pkg;

  localparam int PER_W    = 28;
  localparam int REG_W    = 10;
  localparam int STEP_W   = 16;
  localparam int GAIN_W   = 14;
  localparam int SAMPLE_W = 15;
  localparam int LFSR_W   = 17;

  localparam logic [STEP_W-1:0]   STEP_RESET    = 16'd15052;
  localparam logic [REG_W-1:0]    ATTEN_RESET   = 10'h00f;
  localparam logic [LFSR_W-1:0]   WHITE_TAPS    = 17'h14002;
  localparam logic [LFSR_W-1:0]   PERIODIC_TAPS = 17'h08000;
  localparam logic [LFSR_W-1:0]   SHIFT_PRESET  = 17'h00f35;
  localparam logic [SAMPLE_W-1:0] FULL_SCALE    = 15'h7fff;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic CHIP_TONE  = 1'b0;
  localparam logic CHIP_NOISE = 1'b1;

  localparam logic [2:0] REG_TONE0_PER  = 3'd0;
  localparam logic [2:0] REG_TONE1_PER  = 3'd2;
  localparam logic [2:0] REG_TONE2_PER  = 3'd4;
  localparam logic [2:0] REG_NOISE_CTRL = 3'd6;

  localparam logic [1:0] NOISE_RATE_TONE2 = 2'd3;

  localparam logic [1:0] CHAN_FIRST     = 2'd0;
  localparam logic [1:0] CHAN_LAST_TONE = 2'd2;
  localparam logic [1:0] CHAN_NOISE     = 2'd3;

  typedef struct packed {
    logic       do_write;
    logic       tone_start;
    logic       div_step;
    logic       tone_fin;
    logic       noise_start;
    logic       noise_step;
    logic       mac;
    logic       load_out;
    logic [1:0] chan;
  } cmd_t;

  typedef struct packed {
    logic wrap;
    logic div_done;
    logic noise_done;
    logic out_busy;
  } status_t;

  function automatic logic [GAIN_W-1:0] gain_lookup(input logic [3:0] atten);
    logic [GAIN_W-1:0] g;
    case (atten)
      4'd0:    g = 14'd10922;
      4'd1:    g = 14'd8675;
      4'd2:    g = 14'd6891;
      4'd3:    g = 14'd5473;
      4'd4:    g = 14'd4348;
      4'd5:    g = 14'd3453;
      4'd6:    g = 14'd2743;
      4'd7:    g = 14'd2179;
      4'd8:    g = 14'd1731;
      4'd9:    g = 14'd1374;
      4'd10:   g = 14'd1092;
      4'd11:   g = 14'd867;
      4'd12:   g = 14'd689;
      4'd13:   g = 14'd547;
      4'd14:   g = 14'd434;
      default: g = 14'd0;
    endcase
    return g;
  endfunction

endpackage
`default_nettype wire

// ----- src/dpsg_item_if.sv -----
`default_nettype none
interface dpsg_item_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic       chip_select;
  logic [7:0] write_data;

  modport source(output valid, output operation, output chip_select, output write_data,
                 input ready);
  modport sink(input valid, input operation, input chip_select, input write_data,
               output ready);
endinterface
`default_nettype wire

// ----- src/dpsg_result_if.sv -----
`default_nettype none
interface dpsg_result_if;
  logic        valid;
  logic        ready;
  logic [14:0] sample;

  modport source(output valid, output sample, input ready);
  modport sink(input valid, input sample, output ready);
endinterface
`default_nettype wire

// ----- src/dpsg_ctrl.sv -----
`default_nettype none
module dpsg_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            item_valid,
  input  wire logic            item_op,
  output logic                 item_ready,
  input  wire dpsg_pkg::status_t st,
  output dpsg_pkg::cmd_t       cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_TSTART = 4'd1;
  localparam logic [3:0] S_DIV    = 4'd2;
  localparam logic [3:0] S_TFIN   = 4'd3;
  localparam logic [3:0] S_MAC    = 4'd4;
  localparam logic [3:0] S_NSTART = 4'd5;
  localparam logic [3:0] S_NOISE  = 4'd6;
  localparam logic [3:0] S_OUT    = 4'd7;

  logic [3:0] state, state_next;
  logic [1:0] chan, chan_next;

  always_comb begin
    state_next = state;
    chan_next  = chan;
    cmd        = '0;
    cmd.chan   = chan;
    item_ready = 1'b0;
    case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          if (item_op == dpsg_pkg::OP_TICK) begin
            state_next = S_TSTART;
            chan_next  = dpsg_pkg::CHAN_FIRST;
          end else begin
            cmd.do_write = 1'b1;
          end
        end
      end
      S_TSTART: begin
        cmd.tone_start = 1'b1;
        state_next     = S_DIV;
      end
      S_DIV: begin
        if (!st.wrap || st.div_done) begin
          state_next = S_TFIN;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_TFIN: begin
        cmd.tone_fin = 1'b1;
        state_next   = S_MAC;
      end
      S_MAC: begin
        cmd.mac = 1'b1;
        if (chan == dpsg_pkg::CHAN_NOISE) begin
          state_next = S_OUT;
        end else if (chan == dpsg_pkg::CHAN_LAST_TONE) begin
          chan_next  = dpsg_pkg::CHAN_NOISE;
          state_next = S_NSTART;
        end else begin
          chan_next  = chan + 2'd1;
          state_next = S_TSTART;
        end
      end
      S_NSTART: begin
        cmd.noise_start = 1'b1;
        state_next      = S_NOISE;
      end
      S_NOISE: begin
        if (st.noise_done) begin
          state_next = S_MAC;
        end else begin
          cmd.noise_step = 1'b1;
        end
      end
      S_OUT: begin
        if (!st.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      chan  <= dpsg_pkg::CHAN_FIRST;
    end else begin
      state <= state_next;
      chan  <= chan_next;
    end
  end

endmodule
`default_nettype wire

// ----- src/dpsg_dp.sv -----
`default_nettype none
module dpsg_dp #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [15:0]           cfg_wdata,
  input  wire logic                  chip,
  input  wire logic [7:0]            data,
  input  wire dpsg_pkg::cmd_t        cmd,
  output dpsg_pkg::status_t          st,
  output logic                       res_valid,
  input  wire logic                  res_ready,
  output logic [14:0]                res_sample
);

  localparam int PER_W  = dpsg_pkg::PER_W;
  localparam int ONE_W  = FRAC_BITS + 1;
  localparam int C_W    = PER_W + 1;
  localparam int V_W    = PER_W + 3;
  localparam int CNT_W  = $clog2(FRAC_BITS + 1);
  localparam int PROD_W = ONE_W + dpsg_pkg::GAIN_W;
  localparam int ACC_W  = PROD_W + 2;

  localparam logic [ONE_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic signed [C_W-1:0] ONE_C = {{(C_W - ONE_W){1'b0}}, ONE};
  localparam logic [ACC_W-1:0] CAP =
    {{(ACC_W - dpsg_pkg::SAMPLE_W - FRAC_BITS){1'b0}}, dpsg_pkg::FULL_SCALE,
     {FRAC_BITS{1'b0}}};
  localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(FRAC_BITS);

  // Generator state.
  logic [15:0]              update_step;
  logic [9:0]               regs  [2][8];
  logic [2:0]               latch [2];
  logic [PER_W-1:0]         per   [2][4];
  logic [13:0]              gain  [2][4];
  // Entries 0..2 are the tone chip's tones, entry 3 the noise chip's noise.
  logic signed [C_W-1:0]    cd    [4];
  logic [3:0]               lv;
  logic [16:0]              lfsr;
  logic                     white;

  // Step working registers.
  logic signed [C_W-1:0]    csub;
  logic                     wrap;
  logic [FRAC_BITS-1:0]     nshift, nval, quo;
  logic [PER_W-1:0]         rem;
  logic [CNT_W-1:0]         dcnt;
  logic [ONE_W-1:0]         left;
  logic signed [V_W-1:0]    nacc;
  logic [ONE_W-1:0]         hi;
  logic [ACC_W-1:0]         acc0, acc1;

  // Register write decode.
  logic                     wr_latch, is_period;
  logic [2:0]               wr_reg;
  logic [9:0]               cur, wr_val;
  logic [15:0]              eff;
  logic [25:0]              prod_p;
  logic [PER_W-1:0]         period_val, noise_per;

  always_comb begin
    wr_latch   = data[7];
    wr_reg     = wr_latch ? data[6:4] : latch[chip];
    cur        = regs[chip][wr_reg];
    wr_val     = wr_latch ? {cur[9:4], data[3:0]} : {data[5:0], cur[3:0]};
    is_period  = wr_reg inside {dpsg_pkg::REG_TONE0_PER, dpsg_pkg::REG_TONE1_PER,
                                dpsg_pkg::REG_TONE2_PER};
    eff        = (update_step == 16'd0) ? 16'd1 : update_step;
    prod_p     = eff * wr_val;
    period_val = (prod_p == 26'd0) ? PER_W'(eff) : PER_W'(prod_p);
    if (wr_val[1:0] == dpsg_pkg::NOISE_RATE_TONE2) begin
      noise_per = {per[chip][2][PER_W-2:0], 1'b0};
    end else begin
      noise_per = PER_W'(eff) << (3'd5 + 3'(wr_val[1:0]));
    end
  end

  // Channel selection.
  logic [PER_W-1:0]         p_sel;
  logic [13:0]              g_sel;
  always_comb begin
    if (cmd.chan == dpsg_pkg::CHAN_NOISE) begin
      p_sel = per[dpsg_pkg::CHIP_NOISE][dpsg_pkg::CHAN_NOISE];
      g_sel = gain[dpsg_pkg::CHIP_NOISE][dpsg_pkg::CHAN_NOISE];
    end else begin
      p_sel = per[dpsg_pkg::CHIP_TONE][cmd.chan];
      g_sel = gain[dpsg_pkg::CHIP_TONE][cmd.chan];
    end
  end

  // Tone start and divider step.
  logic signed [C_W-1:0]    csub_next;
  logic [PER_W:0]           rem_sh, rem_diff;
  logic                     ge;
  always_comb begin
    csub_next = cd[cmd.chan] - ONE_C;
    rem_sh    = {rem, nshift[FRAC_BITS-1]};
    rem_diff  = rem_sh - {1'b0, p_sel};
    ge        = rem_sh >= {1'b0, p_sel};
  end

  // Square channel finish: new countdown, level and high time.
  logic signed [V_W-1:0]    vc, vp, vr, vn, vs, v0, vsum, vhalf, vcnew, vtone;
  logic                     qodd, newl;
  always_comb begin
    vc    = V_W'(cd[cmd.chan]);
    vp    = $signed(V_W'(p_sel));
    vr    = $signed(V_W'(rem));
    vn    = $signed(V_W'(nval));
    vs    = V_W'(csub);
    v0    = lv[cmd.chan] ? vc : '0;
    qodd  = quo[0];
    vsum  = qodd ? (vn - vr + vp) : (vn - vr);
    vhalf = vsum >>> 1;
    if (wrap) begin
      newl  = lv[cmd.chan] ^ ~qodd;
      vcnew = vp - vr;
      vtone = v0 + vhalf + ((!qodd && newl) ? vp : '0) - (newl ? vcnew : '0);
    end else begin
      newl  = lv[cmd.chan];
      vcnew = vs;
      vtone = v0 - (lv[cmd.chan] ? vs : '0);
    end
  end

  // Noise step: advance to the next shift or to the end of the sample.
  logic signed [V_W-1:0]    nc, nl, nnext, nc2, nc3, np;
  logic                     nev, nla;
  logic [16:0]              sfb, snew;
  always_comb begin
    nc    = V_W'(cd[dpsg_pkg::CHAN_NOISE]);
    nl    = $signed(V_W'(left));
    np    = $signed(V_W'(per[dpsg_pkg::CHIP_NOISE][dpsg_pkg::CHAN_NOISE]));
    if (nc <= 0) begin
      nnext = nl;
    end else begin
      nnext = (nc < nl) ? nc : nl;
    end
    nc2   = nc - nnext;
    nev   = (nc2 <= 0);
    sfb   = lfsr[0] ? (lfsr ^ (white ? dpsg_pkg::WHITE_TAPS : dpsg_pkg::PERIODIC_TAPS))
                    : lfsr;
    snew  = sfb >> 1;
    nla   = nev ? snew[0] : lv[dpsg_pkg::CHAN_NOISE];
    nc3   = nev ? (nc2 + np) : nc2;
  end

  // Gain multiply.
  logic [ONE_W-1:0]         mac_in;
  logic [PROD_W-1:0]        prod;
  always_comb begin
    mac_in = (cmd.chan == dpsg_pkg::CHAN_NOISE) ? nacc[ONE_W-1:0] : hi;
    prod   = mac_in * g_sel;
  end

  // Per-chip saturation and the final mix.
  logic [14:0]              s0, s1;
  logic [15:0]              mix;
  always_comb begin
    s0  = (acc0 > CAP) ? dpsg_pkg::FULL_SCALE : acc0[FRAC_BITS +: 15];
    s1  = (acc1 > CAP) ? dpsg_pkg::FULL_SCALE : acc1[FRAC_BITS +: 15];
    mix = {1'b0, s0} + {1'b0, s1};
  end

  always_comb begin
    st.wrap       = wrap;
    st.div_done   = (dcnt == '0);
    st.noise_done = (left == '0);
    st.out_busy   = res_valid && !res_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      update_step <= dpsg_pkg::STEP_RESET;
      for (int c = 0; c < 2; c++) begin
        latch[c] <= 3'd0;
        for (int i = 0; i < 8; i++) begin
          regs[c][i] <= i[0] ? dpsg_pkg::ATTEN_RESET : 10'd0;
        end
        for (int i = 0; i < 4; i++) begin
          per[c][i]  <= PER_W'(dpsg_pkg::STEP_RESET);
          gain[c][i] <= 14'd0;
        end
      end
      for (int i = 0; i < 4; i++) begin
        cd[i] <= C_W'(dpsg_pkg::STEP_RESET);
      end
      lv        <= 4'd0;
      lfsr      <= 17'd0;
      white     <= 1'b0;
      wrap      <= 1'b0;
      dcnt      <= '0;
      left      <= '0;
      res_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        update_step <= cfg_wdata;
      end

      if (cmd.do_write) begin
        if (wr_latch) begin
          latch[chip] <= wr_reg;
        end
        if (wr_latch || is_period) begin
          regs[chip][wr_reg] <= wr_val;
        end
        if (is_period) begin
          per[chip][wr_reg[2:1]] <= period_val;
          if (wr_reg == dpsg_pkg::REG_TONE2_PER &&
              regs[chip][dpsg_pkg::REG_NOISE_CTRL][1:0] == dpsg_pkg::NOISE_RATE_TONE2) begin
            per[chip][3] <= {period_val[PER_W-2:0], 1'b0};
          end
        end else if (wr_latch && wr_reg == dpsg_pkg::REG_NOISE_CTRL) begin
          per[chip][3] <= noise_per;
          if (chip == dpsg_pkg::CHIP_NOISE) begin
            white                     <= wr_val[2];
            lfsr                      <= dpsg_pkg::SHIFT_PRESET;
            lv[dpsg_pkg::CHAN_NOISE]  <= dpsg_pkg::SHIFT_PRESET[0];
          end
        end else if (wr_latch) begin
          gain[chip][wr_reg[2:1]] <= dpsg_pkg::gain_lookup(data[3:0]);
        end
      end

      if (cmd.tone_start) begin
        csub   <= csub_next;
        wrap   <= (csub_next <= 0);
        nshift <= FRAC_BITS'(-csub_next);
        nval   <= FRAC_BITS'(-csub_next);
        rem    <= '0;
        quo    <= '0;
        dcnt   <= DIV_STEPS;
      end

      if (cmd.div_step) begin
        rem    <= ge ? rem_diff[PER_W-1:0] : rem_sh[PER_W-1:0];
        quo    <= {quo[FRAC_BITS-2:0], ge};
        nshift <= nshift << 1;
        dcnt   <= dcnt - CNT_W'(1);
      end

      if (cmd.tone_fin) begin
        cd[cmd.chan] <= C_W'(vcnew);
        lv[cmd.chan] <= newl;
        hi           <= vtone[ONE_W-1:0];
      end

      if (cmd.noise_start) begin
        left <= ONE;
        nacc <= '0;
      end

      if (cmd.noise_step) begin
        nacc <= nacc + (lv[dpsg_pkg::CHAN_NOISE] ? nc : '0) - (nla ? nc2 : '0);
        cd[dpsg_pkg::CHAN_NOISE] <= C_W'(nc3);
        lv[dpsg_pkg::CHAN_NOISE] <= nla;
        if (nev) begin
          lfsr <= snew;
        end
        left <= left - nnext[ONE_W-1:0];
      end

      if (cmd.mac) begin
        if (cmd.chan == dpsg_pkg::CHAN_NOISE) begin
          acc1 <= ACC_W'(prod);
        end else if (cmd.chan == dpsg_pkg::CHAN_FIRST) begin
          acc0 <= ACC_W'(prod);
        end else begin
          acc0 <= acc0 + ACC_W'(prod);
        end
      end

      if (cmd.load_out) begin
        res_valid  <= 1'b1;
        res_sample <= mix[15:1];
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/dual_psg_tone_noise_mixer.sv -----
// Dual sound generator mixer. Two three-tone, one-noise generators (a tone chip and a
// noise chip) take register bytes on the item channel with operation 0, chip_select
// choosing the chip; such an item is handled while the block stays idle and gives no
// result. An item with operation 1 advances the tone chip's three tone counters and
// the noise chip's noise counter by one output sample and yields one 15-bit sample:
// the average of the tone chip's summed three tones and the noise chip's noise channel,
// each clipped to full scale, with each channel weighted by its attenuation. update_step
// is written through cfg_we/cfg_wdata; the user must write it only while the block is
// idle, as the block itself does not enforce this; it scales tone and noise periods at
// the next register write. For each tone the controller starts the countdown, runs a
// restoring divider shared by the tones when the countdown wraps in the sample, which
// resolves one quotient bit per cycle, then finishes the tone and weights it; the noise
// channel is then walked one shift register step per cycle and weighted, and the mix follows.
// The finished sample sits in an output register, so a new item is taken while the
// previous sample still waits to be read.
`default_nettype none
module dual_psg_tone_noise_mixer #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cfg_we,
  input  wire logic [15:0]    cfg_wdata,
  dpsg_item_if.sink           item,
  dpsg_result_if.source       result
);

  dpsg_pkg::cmd_t    cmd;
  dpsg_pkg::status_t st;

  // The controller sequences the tones, the noise walk and the mix; it accepts an
  // item only when idle.
  dpsg_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_op    (item.operation),
    .item_ready (item.ready),
    .st         (st),
    .cmd        (cmd)
  );

  // The datapath holds the register files, counters, shift register, divider,
  // gain multiplier and the output register.
  dpsg_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .chip       (item.chip_select),
    .data       (item.write_data),
    .cmd        (cmd),
    .st         (st),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res_sample (result.sample)
  );

endmodule
`default_nettype wire

// ----- src/dpsg_checker.sv -----
`default_nettype none
`include "dual_psg_tone_noise_mixer_defines.svh"
module dpsg_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        item_valid,
  input wire logic        item_ready,
  input wire logic        item_operation,
  input wire logic        result_valid,
  input wire logic        result_ready,
  input wire logic [14:0] result_sample
);

  logic tick_acc, write_acc;
  assign tick_acc  = item_valid && item_ready && (item_operation == dpsg_pkg::OP_TICK);
  assign write_acc = item_valid && item_ready && (item_operation == dpsg_pkg::OP_WRITE);

  `DPSG_ASSERT_RST(a_reset_clears_result, rst |=> !result_valid, "result valid after reset")
  `DPSG_ASSERT_CLK(a_result_holds, result_valid && !result_ready |=> result_valid && $stable(result_sample), "stalled result changed")
  `DPSG_ASSERT_CLK(a_tick_busy, tick_acc |=> !item_ready && !$rose(result_valid), "sample tick not processed over cycles")
  `DPSG_ASSERT_CLK(a_write_quick, write_acc |=> item_ready && !$rose(result_valid), "register write stalled or produced a result")

endmodule

bind dual_psg_tone_noise_mixer dpsg_checker u_dpsg_checker (
  .clk            (clk),
  .rst            (rst),
  .item_valid     (item.valid),
  .item_ready     (item.ready),
  .item_operation (item.operation),
  .result_valid   (result.valid),
  .result_ready   (result.ready),
  .result_sample  (result.sample)
);
`default_nettype wire

// ----- tb/dpsg_mix_checker.sv -----
`timescale 1ns / 100ps
`default_nettype none
module dpsg_mix_checker #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  dpsg_item_if             item,
  dpsg_result_if           result,
  output int               errors,
  output int               pending,
  output int               samples_seen
);
  import dpsg_pkg::*;

  localparam longint ONE = longint'(1) << FRAC_BITS;
  localparam int GAIN_TABLE [16] = '{10922, 8675, 6891, 5473, 4348, 3453, 2743, 2179,
                                     1731, 1374, 1092, 867, 689, 547, 434, 0};

  logic [STEP_W-1:0]   step_reg;
  logic [REG_W-1:0]    regs [2][8];
  logic [2:0]          latch_idx [2];
  longint              per [2][4];
  longint              cnt [2][4];
  bit                  lvl [2][4];
  longint              gain [2][4];
  logic [LFSR_W-1:0]   lfsr [2];
  logic [LFSR_W-1:0]   taps [2];
  logic [SAMPLE_W-1:0] sample_queue [$];

  function automatic longint eff_step();
    return (step_reg == 0) ? 1 : longint'(step_reg);
  endfunction

  function automatic void load_period(int ch, int r);
    longint p;
    p = eff_step() * longint'(regs[ch][r]);
    if (p == 0) p = eff_step();
    per[ch][r >> 1] = p;
    if (r == REG_TONE2_PER && regs[ch][REG_NOISE_CTRL][1:0] == NOISE_RATE_TONE2)
      per[ch][CHAN_NOISE] = 2 * per[ch][CHAN_LAST_TONE];
  endfunction

  function automatic void apply_byte(int ch, logic [7:0] d);
    int r;
    logic [1:0] rate;
    if (d[7]) begin
      r = d[6:4];
      latch_idx[ch] = d[6:4];
      regs[ch][r] = {regs[ch][r][9:4], d[3:0]};
      if (r == REG_TONE0_PER || r == REG_TONE1_PER || r == REG_TONE2_PER) begin
        load_period(ch, r);
      end else if (r == REG_NOISE_CTRL) begin
        taps[ch] = regs[ch][r][2] ? WHITE_TAPS : PERIODIC_TAPS;
        rate = regs[ch][r][1:0];
        per[ch][CHAN_NOISE] = (rate == NOISE_RATE_TONE2) ? 2 * per[ch][CHAN_LAST_TONE]
                                                         : eff_step() << (5 + rate);
        lfsr[ch] = SHIFT_PRESET;
        lvl[ch][CHAN_NOISE] = SHIFT_PRESET[0];
      end else begin
        gain[ch][r >> 1] = GAIN_TABLE[d[3:0]];
      end
    end else begin
      r = latch_idx[ch];
      if (r == REG_TONE0_PER || r == REG_TONE1_PER || r == REG_TONE2_PER) begin
        regs[ch][r] = {d[5:0], regs[ch][r][3:0]};
        load_period(ch, r);
      end
    end
  endfunction

  // High time of one square channel over one output sample.
  function automatic longint walk_tone(int ch, int i);
    longint p, c, v, m;
    p = per[ch][i];
    c = cnt[ch][i];
    v = lvl[ch][i] ? c : 0;
    c -= ONE;
    if (c <= 0) begin
      m = (-c) / p + 1;
      c += m * p;
      v += (m / 2) * p;
      if (m[0]) begin
        lvl[ch][i] = !lvl[ch][i];
        if (lvl[ch][i]) v += p;
      end
    end
    if (lvl[ch][i]) v -= c;
    cnt[ch][i] = c;
    return v;
  endfunction

  // High time of the noise channel, walked one shift at a time.
  function automatic longint walk_noise(int ch);
    longint p, c, left, v, nx;
    logic [LFSR_W-1:0] s;
    p = per[ch][CHAN_NOISE];
    c = cnt[ch][CHAN_NOISE];
    left = ONE;
    v = 0;
    do begin
      nx = (c < left) ? c : left;
      if (nx <= 0) nx = left;
      if (lvl[ch][CHAN_NOISE]) v += c;
      c -= nx;
      if (c <= 0) begin
        s = lfsr[ch];
        if (s[0]) s ^= taps[ch];
        s = s >> 1;
        lfsr[ch] = s;
        lvl[ch][CHAN_NOISE] = s[0];
        c += p;
        if (lvl[ch][CHAN_NOISE]) v += p;
      end
      if (lvl[ch][CHAN_NOISE]) v -= c;
      left -= nx;
    end while (left > 0);
    cnt[ch][CHAN_NOISE] = c;
    return v;
  endfunction

  function automatic longint clip_scale(longint a);
    longint cap;
    cap = longint'(FULL_SCALE) * ONE;
    if (a < 0) a = 0;
    if (a > cap) a = cap;
    return a / ONE;
  endfunction

  function automatic logic [SAMPLE_W-1:0] mix_sample();
    longint hi [2][4];
    longint tone_acc, noise_acc, sum;
    for (int ch = 0; ch < 2; ch++) begin
      for (int i = 0; i < 3; i++) hi[ch][i] = walk_tone(ch, i);
      hi[ch][CHAN_NOISE] = walk_noise(ch);
    end
    tone_acc = hi[CHIP_TONE][0] * gain[CHIP_TONE][0] + hi[CHIP_TONE][1] * gain[CHIP_TONE][1]
             + hi[CHIP_TONE][2] * gain[CHIP_TONE][2];
    noise_acc = hi[CHIP_NOISE][CHAN_NOISE] * gain[CHIP_NOISE][CHAN_NOISE];
    sum = (clip_scale(tone_acc) + clip_scale(noise_acc)) >> 1;
    return sum[SAMPLE_W-1:0];
  endfunction

  always @(posedge clk) begin
    logic [SAMPLE_W-1:0] want;
    if (rst) begin
      step_reg = STEP_RESET;
      for (int ch = 0; ch < 2; ch++) begin
        for (int r = 0; r < 8; r++) regs[ch][r] = r[0] ? ATTEN_RESET : '0;
        for (int i = 0; i < 4; i++) begin
          per[ch][i]  = STEP_RESET;
          cnt[ch][i]  = STEP_RESET;
          lvl[ch][i]  = 1'b0;
          gain[ch][i] = 0;
        end
        latch_idx[ch] = '0;
        lfsr[ch] = '0;
        taps[ch] = '0;
      end
      sample_queue.delete();
      errors = 0;
      samples_seen = 0;
    end else begin
      if (cfg_we) step_reg = cfg_wdata;
      if (item.valid && item.ready) begin
        if (item.operation == OP_WRITE) apply_byte(item.chip_select, item.write_data);
        else sample_queue.push_back(mix_sample());
      end
      if (result.valid && result.ready) begin
        samples_seen++;
        if (sample_queue.size() == 0) begin
          if (errors < 10) $display("%0t: sample %0h arrived with nothing expected",
                                    $realtime, result.sample);
          errors++;
        end else begin
          want = sample_queue.pop_front();
          if (result.sample !== want) begin
            if (errors < 10) $display("%0t: sample mismatch, expected %0h got %0h",
                                      $realtime, want, result.sample);
            errors++;
          end
        end
      end
    end
    pending <= sample_queue.size();
  end
endmodule
`default_nettype wire

// ----- tb/tb_dual_psg_tone_noise_mixer.sv -----
`timescale 1ns / 100ps
`default_nettype none
module tb_dual_psg_tone_noise_mixer;
  import dpsg_pkg::*;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  int          errors;
  int          pending;
  int          samples_seen;
  int          ticks_sent;
  int          writes_sent;
  int          burst_left;
  logic [9:0]  stall_cnt;

  dpsg_item_if   item ();
  dpsg_result_if result ();

  dual_psg_tone_noise_mixer uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .item(item), .result(result)
  );

  // The checker sees every handshake and configuration write and keeps its own
  // model of both generators; the top only drives stimulus.
  dpsg_mix_checker checker_i (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .item(item), .result(result),
    .errors(errors), .pending(pending), .samples_seen(samples_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The sample receiver cycles through four stall behaviors: always ready,
  // randomly ready, ready when stall_cnt[2:0] is zero, and long on/off stretches.
  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
      stall_cnt <= '0;
    end else begin
      stall_cnt <= stall_cnt + 1'b1;
      case (stall_cnt[9:8])
        2'd0: result.ready <= 1'b1;
        2'd1: result.ready <= ($urandom_range(0, 9) < 7);
        2'd2: result.ready <= (stall_cnt[2:0] == 3'd0);
        default: result.ready <= stall_cnt[4];
      endcase
    end
  end

  // Offer one item and hold it until it is taken. Items go out in bursts;
  // between bursts the valid line often drops for a random number of cycles.
  task automatic send(input logic op, input logic cs, input logic [7:0] d);
    int gap;
    item.valid <= 1'b1;
    item.operation <= op;
    item.chip_select <= cs;
    item.write_data <= d;
    do @(posedge clk); while (!item.ready);
    if (op == OP_TICK) ticks_sent++;
    else writes_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        item.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stop sending and wait until every predicted sample has been read, plus a
  // little slack since a register write gives no sample to wait for.
  task automatic settle();
    item.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic set_step(input logic [15:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Periods are only scaled when written, so after a step change tone 2 and the
  // noise control are rewritten on both chips. The rate stays off tone 2 here so
  // the noise channel never runs with a period left over from a tiny step.
  task automatic restore();
    for (int c = 0; c < 2; c++) begin
      send(OP_WRITE, c[0], {1'b1, REG_TONE2_PER, 4'($urandom)});
      send(OP_WRITE, c[0], {2'b00, 6'($urandom)});
      send(OP_WRITE, c[0], {1'b1, REG_NOISE_CTRL, 1'b0, 1'($urandom),
                            2'($urandom_range(0, 2))});
    end
  endtask

  // Mostly well-formed latch plus data pairs and sample ticks, with some lone
  // latches and raw bytes. With a very small step the noise control is kept
  // out, since its period would then be so short that a sample takes many steps.
  task automatic random_items(input int n, input int tick_pct, input bit allow_ctrl);
    int k, r;
    logic cs;
    logic [2:0] rg;
    logic [7:0] d;
    k = 0;
    while (k < n) begin
      r = $urandom_range(0, 99);
      cs = $urandom_range(0, 1);
      rg = $urandom_range(0, 7);
      if (!allow_ctrl && rg == REG_NOISE_CTRL) rg = 3'd7;
      d = $urandom;
      if (!allow_ctrl && d[7] && d[6:4] == REG_NOISE_CTRL) d[6:4] = 3'd7;
      if (r < tick_pct) begin
        send(OP_TICK, cs, d);
        k++;
      end else if (r < tick_pct + (100 - tick_pct) * 6 / 10) begin
        send(OP_WRITE, cs, {1'b1, rg, 4'($urandom)});
        send(OP_WRITE, cs, {1'b0, 7'($urandom)});
        k += 2;
      end else if (r < 95) begin
        send(OP_WRITE, cs, {1'b1, rg, 4'($urandom)});
        k++;
      end else begin
        send(OP_WRITE, cs, d);
        k++;
      end
    end
  endtask

  initial begin
    logic [15:0] steps [8];
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    item.valid <= 1'b0;
    item.operation <= OP_WRITE;
    item.chip_select <= CHIP_TONE;
    item.write_data <= '0;
    ticks_sent = 0;
    writes_sent = 0;
    burst_left = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset step. A tick right after reset is silent, and
    // its chip select and data must not matter.
    send(OP_TICK, CHIP_TONE, 8'h00);
    send(OP_TICK, CHIP_NOISE, 8'hff);
    // Tone 0 at full volume with the longest period.
    send(OP_WRITE, CHIP_TONE, 8'h90);
    send(OP_WRITE, CHIP_TONE, 8'h8f);
    send(OP_WRITE, CHIP_TONE, 8'h3f);
    send(OP_TICK, CHIP_TONE, 8'h00);
    // Tone 1 with a zero period register, which falls back to one step.
    send(OP_WRITE, CHIP_TONE, 8'hb0);
    send(OP_WRITE, CHIP_TONE, 8'ha0);
    send(OP_TICK, CHIP_TONE, 8'h00);
    // Tone 2 with the shortest nonzero period.
    send(OP_WRITE, CHIP_TONE, 8'hd4);
    send(OP_WRITE, CHIP_TONE, 8'hc1);
    send(OP_WRITE, CHIP_TONE, 8'h00);
    send(OP_TICK, CHIP_NOISE, 8'h00);
    // Noise chip: white noise at the fastest fixed rate, then the rate that
    // follows tone 2, then a tone 2 write that must also move the noise period.
    send(OP_WRITE, CHIP_NOISE, 8'hf0);
    send(OP_WRITE, CHIP_NOISE, 8'he4);
    send(OP_TICK, CHIP_NOISE, 8'h00);
    send(OP_WRITE, CHIP_NOISE, 8'he7);
    send(OP_WRITE, CHIP_NOISE, 8'hc5);
    send(OP_WRITE, CHIP_NOISE, 8'h12);
    send(OP_TICK, CHIP_TONE, 8'hff);
    // A data byte after latching an attenuation register changes nothing.
    send(OP_WRITE, CHIP_NOISE, 8'hf3);
    send(OP_WRITE, CHIP_NOISE, 8'h7f);
    send(OP_TICK, CHIP_TONE, 8'h00);
    // Periodic noise at the slowest fixed rate.
    send(OP_WRITE, CHIP_NOISE, 8'he2);
    send(OP_TICK, CHIP_NOISE, 8'h00);

    // Random traffic at the reset step, with a full drain in the middle.
    random_items(100, 40, 1'b1);
    settle();
    random_items(100, 40, 1'b1);

    // Steps: both extremes, zero (taken as one), 256, random and the reset step.
    steps = '{16'hffff, 16'h0000, 16'h0001, 16'($urandom_range(256, 65535)),
              16'($urandom_range(256, 65535)), 16'd256,
              16'($urandom_range(256, 65535)), STEP_RESET};
    foreach (steps[i]) begin
      settle();
      set_step(steps[i]);
      restore();
      if (steps[i] < 16'd256) random_items(40, 8, 1'b0);
      else random_items(170, 40, 1'b1);
    end

    settle();
    $display("Sent %0d register writes and %0d sample ticks over %0d step settings.",
             writes_sent, ticks_sent, 9);
    $display("Checked %0d samples against the prediction, %0d mismatches.",
             samples_seen, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("FAIL");
    $finish;
  end
endmodule
`default_nettype wire
